FILE: hw/rtl/table_linear_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Table linear interpolator assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define TLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// Table linear interpolator package
// Field widths, command and status codes shared by the interpolator modules.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned CNT_CFG_W   = 9;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;

  // Operand magnitudes, product and clamped quotient of the multiply/divide unit
  localparam int unsigned MAG_W  = DATA_W + 1;
  localparam int unsigned PROD_W = 2 * MAG_W;
  localparam int unsigned QUOT_W = DATA_W + 3;

  typedef logic [MAG_W-1:0]    mag_t;
  typedef logic [QUOT_W-1:0]   quot_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FEW  = 2'd1;
  localparam status_t ST_ZERO = 2'd2;
  localparam status_t ST_SAT  = 2'd3;

endpackage

FILE: hw/rtl/tli_muldiv.sv
// ----------------------------------------------------------------------------
// Table linear interpolator multiply/divide unit
// Shift-add multiply of two magnitudes, then restoring division of the product
// by a third; the quotient is clamped to 2^34.
// ----------------------------------------------------------------------------
module tli_muldiv (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  tli_pkg::mag_t a_i,
  input  tli_pkg::mag_t b_i,
  input  tli_pkg::mag_t d_i,
  output logic          done_o,
  output tli_pkg::quot_t quot_o
);
  import tli_pkg::*;

  localparam int unsigned CNT_W = $clog2(PROD_W);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL  = 4'b0010,
    MD_DIV  = 4'b0100,
    MD_DONE = 4'b1000
  } md_state_e;

  md_state_e           state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [MAG_W:0]      rem_q, rem_d;
  mag_t                a_q, d_q;
  logic [MAG_W:0]      mul_sum;
  logic [PROD_W:0]     mul_shift;
  logic [MAG_W:0]      div_trial;
  logic                div_ge;
  logic                clamp;

  assign mul_sum   = {1'b0, prod_q[PROD_W-1:MAG_W]} + (prod_q[0] ? {1'b0, a_q} : '0);
  assign mul_shift = {mul_sum, prod_q[MAG_W-1:0]};
  assign div_trial = {rem_q[MAG_W-1:0], prod_q[PROD_W-1]};
  assign div_ge    = div_trial >= {1'b0, d_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          prod_d  = {{MAG_W{1'b0}}, b_i};
          rem_d   = '0;
          cnt_d   = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        prod_d = mul_shift[PROD_W:1];
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MAG_W - 1)) begin
          cnt_d   = '0;
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_d  = div_ge ? (div_trial - {1'b0, d_q}) : div_trial;
        prod_d = {prod_q[PROD_W-2:0], div_ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PROD_W - 1)) begin
          state_d = MD_DONE;
        end
      end
      MD_DONE: state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    if (state_q == MD_IDLE && start_i) begin
      a_q <= a_i;
      d_q <= d_i;
    end
  end

  assign clamp  = (|prod_q[PROD_W-1:QUOT_W]) || (prod_q[QUOT_W-1] && (|prod_q[QUOT_W-2:0]));
  assign quot_o = clamp ? {1'b1, {(QUOT_W-1){1'b0}}} : prod_q[QUOT_W-1:0];
  assign done_o = state_q == MD_DONE;

endmodule

FILE: hw/rtl/table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Table linear interpolator
// Holds a table of signed Q16.16 points; interpolates or extrapolates a query.
// ----------------------------------------------------------------------------
// Channels: the s_axis group takes one transaction per item. tuser = 0 loads
// entry entry_index with (x_value, y_value) and gives no result; tuser = 1
// queries at x_value and gives one m_axis transaction with y_result and
// segment in tdata and the status code in tuser. The cfg channel writes
// points_in_use and is always ready; write it only while the block is idle.
// Sequence: a query with fewer than two points is answered in the cycle after
// acceptance. Otherwise a query first makes table probes, p bisection steps
// with p at most ceil(log2(n-1)) (one read port on each table memory, each
// probe a read state then a compare state), then runs the multiply/divide
// unit (33 shift-add steps, 66 restoring divide steps, one done state) and
// presents the result. A zero-width segment skips the unit. One item is in
// work at a time; the next is accepted the cycle after the result
// transaction. Reset clears points_in_use and the control state; table
// contents stay undefined until loaded. While m_axis is stalled the result
// holds and no new item is accepted.
// ----------------------------------------------------------------------------
`include "table_linear_interpolator_macros.svh"

module table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // entry_index[7:0], x_value[39:8], y_value[71:40]
  input  logic [tli_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // cmd[0]
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // y_result[31:0], segment[39:32]
  output logic [tli_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // status[1:0]
  output tli_pkg::status_t                 m_axis_tuser_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tli_pkg::CNT_CFG_W-1:0]    cfg_data_i
);
  import tli_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned SW = DATA_W + 4;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RD0  = 11'b00000000010,
    S_RDN  = 11'b00000000100,
    S_ASC  = 11'b00000001000,
    S_BIS  = 11'b00000010000,
    S_CMP  = 11'b00000100000,
    S_RDJ  = 11'b00001000000,
    S_RDK  = 11'b00010000000,
    S_SUB  = 11'b00100000000,
    S_MD   = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_CFG_W-1:0]   points_q;
  logic [DATA_W-1:0]      xmem [TABLE_DEPTH];
  logic [DATA_W-1:0]      ymem [TABLE_DEPTH];
  logic [DATA_W-1:0]      xrd_q, yrd_q;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic                   wr_en;
  logic                   in_acc;
  logic [IDX_W-1:0]       in_idx;
  logic [DATA_W-1:0]      in_x, in_y;
  logic [31:0]            idx_ext;
  logic [CNT_CFG_W-1:0]   n_use;
  logic [31:0]            n_m1_ext;
  logic signed [DATA_W-1:0] x_q, x0_q, xj_q, yj_q;
  logic                   ascnd_q;
  logic [AW-1:0]          lo_q, hi_q, mid_q;
  logic [AW:0]            mid_sum;
  logic                   more_probes;
  logic                   go_right;
  logic [MAG_W-1:0]       dxq, dy, dx;
  mag_t                   dxq_mag, dy_mag, dx_mag;
  logic                   neg_q;
  logic                   md_start, md_done;
  quot_t                  md_quot;
  logic signed [SW-1:0]   sum;
  logic [31:0]            lo_ext;
  logic [DATA_W-1:0]      res_q;
  logic [IDX_W-1:0]       seg_q;
  status_t                st_q;

  assign in_idx   = s_axis_tdata_i[IDX_W-1:0];
  assign in_x     = s_axis_tdata_i[IDX_W+DATA_W-1:IDX_W];
  assign in_y     = s_axis_tdata_i[IDX_W+2*DATA_W-1:IDX_W+DATA_W];
  assign idx_ext  = 32'(in_idx);
  assign wr_addr  = idx_ext[AW-1:0];

  assign s_axis_tready_o = state_q == S_IDLE;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en    = in_acc && (s_axis_tuser_i == CMD_LOAD) && (idx_ext < TABLE_DEPTH);
  assign cfg_ready_o = 1'b1;

  assign n_use    = (32'(points_q) > TABLE_DEPTH) ? CNT_CFG_W'(TABLE_DEPTH) : points_q;
  assign n_m1_ext = 32'(n_use) - 32'd1;

  assign mid_sum     = {1'b0, hi_q} + {1'b0, lo_q};
  assign more_probes = {1'b0, hi_q} > ({1'b0, lo_q} + 1'b1);
  assign go_right    = (x_q >= $signed(xrd_q)) == ascnd_q;

  assign dxq = {x_q[DATA_W-1], x_q} - {xj_q[DATA_W-1], xj_q};
  assign dy  = {yrd_q[DATA_W-1], yrd_q} - {yj_q[DATA_W-1], yj_q};
  assign dx  = {xrd_q[DATA_W-1], xrd_q} - {xj_q[DATA_W-1], xj_q};
  assign dxq_mag = dxq[MAG_W-1] ? -dxq : dxq;
  assign dy_mag  = dy[MAG_W-1] ? -dy : dy;
  assign dx_mag  = dx[MAG_W-1] ? -dx : dx;
  assign md_start = (state_q == S_SUB) && (xrd_q != xj_q);

  assign sum = neg_q ? (SW'(yj_q) - $signed({1'b0, md_quot}))
                     : (SW'(yj_q) + $signed({1'b0, md_quot}));
  assign lo_ext = 32'(lo_q);

  always_comb begin
    rd_addr = lo_q;
    case (state_q)
      S_RD0:   rd_addr = '0;
      S_RDN:   rd_addr = hi_q;
      S_BIS:   rd_addr = mid_sum[AW:1];
      S_RDK:   rd_addr = lo_q + 1'b1;
      default: rd_addr = lo_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && s_axis_tuser_i == CMD_QUERY) begin
          state_d = (n_use < CNT_CFG_W'(2)) ? S_OUT : S_RD0;
        end
      end
      S_RD0:   state_d = S_RDN;
      S_RDN:   state_d = S_ASC;
      S_ASC:   state_d = S_BIS;
      S_BIS:   state_d = more_probes ? S_CMP : S_RDJ;
      S_CMP:   state_d = S_BIS;
      S_RDJ:   state_d = S_RDK;
      S_RDK:   state_d = S_SUB;
      S_SUB:   state_d = md_start ? S_MD : S_OUT;
      S_MD:    state_d = md_done ? S_OUT : S_MD;
      S_OUT:   state_d = m_axis_tready_i ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      points_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        points_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      xmem[wr_addr] <= in_x;
      ymem[wr_addr] <= in_y;
    end
    xrd_q <= xmem[rd_addr];
    yrd_q <= ymem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        x_q   <= $signed(in_x);
        lo_q  <= '0;
        hi_q  <= n_m1_ext[AW-1:0];
        res_q <= '0;
        seg_q <= '0;
        st_q  <= ST_FEW;
      end
      S_RDN: x0_q <= $signed(xrd_q);
      S_ASC: ascnd_q <= $signed(xrd_q) >= x0_q;
      S_BIS: mid_q <= mid_sum[AW:1];
      S_CMP: begin
        if (go_right) begin
          lo_q <= mid_q;
        end else begin
          hi_q <= mid_q;
        end
      end
      S_RDK: begin
        xj_q <= $signed(xrd_q);
        yj_q <= $signed(yrd_q);
      end
      S_SUB: begin
        seg_q <= lo_ext[IDX_W-1:0];
        neg_q <= dxq[MAG_W-1] ^ dy[MAG_W-1] ^ dx[MAG_W-1];
        res_q <= yj_q;
        st_q  <= ST_ZERO;
      end
      S_MD: begin
        if (md_done) begin
          if (sum > SW'(32'sh7FFF_FFFF)) begin
            res_q <= 32'h7FFF_FFFF;
            st_q  <= ST_SAT;
          end else if (sum < SW'(32'sh8000_0000)) begin
            res_q <= 32'h8000_0000;
            st_q  <= ST_SAT;
          end else begin
            res_q <= sum[DATA_W-1:0];
            st_q  <= ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

  tli_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (dxq_mag),
    .b_i     (dy_mag),
    .d_i     (dx_mag),
    .done_o  (md_done),
    .quot_o  (md_quot)
  );

  assign m_axis_tvalid_o = state_q == S_OUT;
  assign m_axis_tdata_o  = {seg_q, res_q};
  assign m_axis_tuser_o  = st_q;

  `TLI_ASSERT_NOW(a_one_side, m_axis_tvalid_o, !s_axis_tready_o,
                  "input accepted while a result is pending")
  `TLI_ASSERT_NOW(a_few_zero, m_axis_tvalid_o && (m_axis_tuser_o == ST_FEW),
                  m_axis_tdata_o == '0, "short-table result carries nonzero data")
  `TLI_ASSERT_NEXT(a_few_fast,
                   in_acc && (s_axis_tuser_i == CMD_QUERY) && (n_use < CNT_CFG_W'(2)),
                   m_axis_tvalid_o, "short-table query not answered at once")
  `TLI_ASSERT_NOW(a_seg_range, m_axis_tvalid_o && (m_axis_tuser_o != ST_FEW),
                  (lo_ext + 32'd2) <= 32'(n_use), "segment beyond table end")

endmodule

FILE: verif/tb_table_linear_interpolator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Table linear interpolator testbench
// Starts with a short table of directed loads, point-count writes and queries
// at the extremes. It then runs random phases. Each phase loads a shaped table
// (ascending, descending, unordered or with repeated x), sets the point count
// once the block is idle, and queries near points, between them, beyond the
// ends and at random. The sender works in bursts and the receiver stalls in
// changing patterns. Each result is checked against a directed expectation or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_table_linear_interpolator;
  import tli_pkg::*;

  localparam int unsigned TBL_DEPTH     = 256;
  localparam int unsigned RANDOM_ITEMS  = 1450;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned END_CYCLES    = 160;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam longint unsigned Q_CLAMP   = 64'h4_0000_0000;
  localparam longint RES_MAX            = 64'sh7FFF_FFFF;
  localparam longint RES_MIN            = -64'sh8000_0000;

  typedef struct packed {
    logic [31:0] y_result;
    logic [7:0]  segment;
    status_t     status;
  } interp_res_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_e;
  typedef enum int unsigned {SCALE_FULL, SCALE_MID, SCALE_TINY, SCALE_GRID} scale_e;
  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKED} rx_mode_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic        has_want;
    interp_res_t want;
  } stim_row_t;

  localparam int unsigned N_DIRECTED = 24;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_QUERY, 8'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 8'd0, ST_FEW}},
    '{ROW_CFG,   8'd0,  32'd1,         32'h0000_0000, 1'b0, '0},
    '{ROW_QUERY, 8'd0,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 8'd0, ST_FEW}},
    '{ROW_LOAD,  8'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_LOAD,  8'd1,  32'h0001_0000, 32'h7FFF_0000, 1'b0, '0},
    '{ROW_CFG,   8'd0,  32'd2,         32'h0000_0000, 1'b0, '0},
    '{ROW_QUERY, 8'd0,  32'h0000_8000, 32'h0000_0000, 1'b0, '0},
    '{ROW_QUERY, 8'd0,  32'h0001_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_QUERY, 8'hFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{32'h7FFF_FFFF, 8'd0, ST_SAT}},
    '{ROW_QUERY, 8'd0,  32'h8000_0000, 32'h0000_0000, 1'b1,
      '{32'h8000_0000, 8'd0, ST_SAT}},
    '{ROW_LOAD,  8'd2,  32'h0001_0000, 32'h0000_0005, 1'b0, '0},
    '{ROW_CFG,   8'd0,  32'd3,         32'h0000_0000, 1'b0, '0},
    '{ROW_QUERY, 8'd0,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
      '{32'h7FFF_0000, 8'd1, ST_ZERO}},
    '{ROW_QUERY, 8'd0,  32'h8000_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_QUERY, 8'd0,  32'h0001_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_LOAD,  8'hFF, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{ROW_LOAD,  8'd0,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{ROW_LOAD,  8'd1,  32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG,   8'd0,  32'd2,         32'h0000_0000, 1'b0, '0},
    '{ROW_QUERY, 8'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_QUERY, 8'd0,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{ROW_QUERY, 8'd0,  32'h8000_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,   8'd0,  32'd0,         32'h0000_0000, 1'b0, '0},
    '{ROW_QUERY, 8'h5A, 32'h1234_5678, 32'hA5A5_A5A5, 1'b1, '{32'h0, 8'd0, ST_FEW}}
  };

  logic                   clk_i;
  logic                   rst_ni    = 1'b0;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tready  = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CNT_CFG_W-1:0]   cfg_data  = '0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  status_t                m_axis_tuser_o;
  logic                   cfg_ready_o;

  logic signed [31:0]     pt_x [TBL_DEPTH];
  logic signed [31:0]     pt_y [TBL_DEPTH];
  logic [CNT_CFG_W-1:0]   points_cfg = '0;
  interp_res_t            pending_results [$];
  int unsigned            mismatch_count = 0;
  int unsigned            burst_left = 0;
  int unsigned            stall_left = 0;
  rx_mode_e               rx_mode = RX_OPEN;

  table_linear_interpolator #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic interp_res_t interp_predict(logic signed [31:0] xq);
    interp_res_t       r;
    int unsigned       n, lo, hi, mid, j;
    logic              ascend, neg;
    longint            xj, xk, yj, yk, dxq, dy, dx, sum;
    longint unsigned   q;
    r = '{32'h0, 8'd0, ST_FEW};
    n = (points_cfg > TBL_DEPTH) ? TBL_DEPTH : points_cfg;
    if (n < 2) return r;
    ascend = (pt_x[n-1] >= pt_x[0]);
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (hi + lo) >> 1;
      if ((xq >= pt_x[mid]) == ascend) lo = mid;
      else hi = mid;
    end
    j = (lo > n - 2) ? n - 2 : lo;
    xj = pt_x[j];
    xk = pt_x[j+1];
    yj = pt_y[j];
    yk = pt_y[j+1];
    r.segment = j[7:0];
    if (xj == xk) begin
      r.y_result = yj[31:0];
      r.status = ST_ZERO;
      return r;
    end
    dxq = longint'(xq) - xj;
    dy = yk - yj;
    dx = xk - xj;
    q = (abs64(dxq) * abs64(dy)) / abs64(dx);
    neg = ((dxq < 0) != (dy < 0)) != (dx < 0);
    if (q == 0) neg = 1'b0;
    if (q > Q_CLAMP) q = Q_CLAMP;
    sum = neg ? yj - longint'(q) : yj + longint'(q);
    r.status = ST_OK;
    if (sum > RES_MAX) begin
      r.y_result = 32'h7FFF_FFFF;
      r.status = ST_SAT;
    end else if (sum < RES_MIN) begin
      r.y_result = 32'h8000_0000;
      r.status = ST_SAT;
    end else begin
      r.y_result = sum[31:0];
    end
    return r;
  endfunction

  function automatic int rand_coord(scale_e sc);
    case (sc)
      SCALE_FULL: return $urandom;
      SCALE_MID:  return int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
      SCALE_TINY: return $urandom_range(0, 7);
      default:    return (int'($urandom_range(0, 64)) - 32) <<< 16;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_item(logic cmd, logic [7:0] idx, logic [31:0] xv, logic [31:0] yv,
                           logic has_want, interp_res_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {yv, xv, idx};
    s_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (cmd == CMD_LOAD) begin
      pt_x[idx] = xv;
      pt_y[idx] = yv;
    end else begin
      pending_results.push_back(has_want ? want : interp_predict(xv));
    end
  endtask

  task automatic wait_idle(int unsigned extra);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_points_cfg(logic [CNT_CFG_W-1:0] v);
    wait_idle(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    points_cfg = v;
  endtask

  // Check each result transaction, then pick the next stall pattern step.
  always @(posedge clk_i) begin : rx_side
    interp_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata_o[31:0], 32'h0);
      end else begin
        want = pending_results.pop_front();
        check_field("y_result", m_axis_tdata_o[31:0], want.y_result);
        check_field("segment", 32'(m_axis_tdata_o[39:32]), 32'(want.segment));
        check_field("status", 32'(m_axis_tuser_o), 32'(want.status));
      end
    end
    if (stall_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (rx_mode)
      RX_OPEN:     m_tready <= 1'b1;
      RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_tready <= (stall_left % 3) != 0;
      default:     m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin : stimulus
    int              tx [$];
    int              ty [$];
    int unsigned     i, j, k, n_cfg, n_eff, n_q, phase, random_items;
    longint          a, b;
    logic [31:0]     xq;
    scale_e          sc;
    random_items = 0;
    phase = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_DIRECTED; i++) begin
      case (DIRECTED[i].kind)
        ROW_LOAD:  send_item(CMD_LOAD, DIRECTED[i].idx, DIRECTED[i].x, DIRECTED[i].y,
                             1'b0, '0);
        ROW_QUERY: send_item(CMD_QUERY, DIRECTED[i].idx, DIRECTED[i].x, DIRECTED[i].y,
                             DIRECTED[i].has_want, DIRECTED[i].want);
        default:   write_points_cfg(DIRECTED[i].x[CNT_CFG_W-1:0]);
      endcase
    end

    while (random_items < RANDOM_ITEMS) begin
      // Start with the full, over-range point count so every entry gets written.
      k = $urandom_range(0, 99);
      if (phase == 0) n_cfg = 511;
      else if (k < 6) n_cfg = $urandom_range(0, 1);
      else if (k < 9) n_cfg = $urandom_range(0, 1) ? 256 : 511;
      else if (k < 11) n_cfg = $urandom_range(257, 510);
      else if (k < 75) n_cfg = $urandom_range(2, 8);
      else n_cfg = $urandom_range(9, 48);
      n_eff = (n_cfg > TBL_DEPTH) ? TBL_DEPTH : n_cfg;
      sc = (phase == 0) ? SCALE_FULL : scale_e'($urandom_range(0, 3));

      tx.delete();
      ty.delete();
      for (i = 0; i < n_eff; i++) begin
        tx.push_back(rand_coord(sc));
        ty.push_back(rand_coord(scale_e'($urandom_range(0, 3))));
      end
      k = $urandom_range(0, 99);
      if (k < 50) tx.sort();
      else if (k < 85) tx.rsort();

      for (i = 0; i < n_eff; i++) begin
        if (n_eff < TBL_DEPTH && $urandom_range(0, 7) == 0) begin
          send_item(CMD_LOAD, 8'($urandom_range(n_eff, TBL_DEPTH - 1)), $urandom, $urandom,
                    1'b0, '0);
          random_items++;
        end
        send_item(CMD_LOAD, 8'(i), tx[i], ty[i], 1'b0, '0);
        random_items++;
      end
      write_points_cfg(CNT_CFG_W'(n_cfg));

      n_q = $urandom_range(10, 40);
      for (i = 0; i < n_q; i++) begin
        k = $urandom_range(0, 99);
        if (k < 8) begin
          send_item(CMD_LOAD, 8'($urandom), $urandom, $urandom, 1'b0, '0);
        end else begin
          if (tx.size() == 0 || k < 30) begin
            xq = $urandom;
          end else begin
            j = $urandom_range(0, tx.size() - 1);
            if (k < 55) begin
              xq = tx[j] + int'($urandom_range(0, 2)) - 1;
            end else if (k < 85) begin
              a = tx[j];
              b = tx[(j + 1) % tx.size()];
              xq = 32'(a + (b - a) * longint'($urandom_range(0, 1000)) / 1000);
            end else begin
              xq = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
          end
          send_item(CMD_QUERY, 8'($urandom), xq, $urandom, 1'b0, '0);
        end
        random_items++;
        if ($urandom_range(0, 99) == 0) wait_idle(SETTLE_CYCLES);
      end
      phase++;
    end

    wait_idle(END_CYCLES);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: table_linear_interpolator.f
+incdir+hw/rtl
hw/rtl/tli_pkg.sv
hw/rtl/tli_muldiv.sv
hw/rtl/table_linear_interpolator.sv
verif/tb_table_linear_interpolator.sv
